// ===== rtl/core/upn_pkg.sv =====
// ----------------------------------------------------------------------------
// upn_pkg
// Shared types and constants for the URL path normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upn_pkg;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // One result byte with its flags
  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       last;
    logic       pend;
    logic       bad;
  } upn_res_t;

  // All results caused by one input byte
  typedef struct packed {
    upn_res_t [MaxRes-1:0] item;
    logic [CntW-1:0]       cnt;
  } upn_burst_t;

endpackage

`default_nettype wire

// ===== rtl/core/upn_if.sv =====
// ----------------------------------------------------------------------------
// upn_in_if / upn_out_if
// Valid/ready channels for path bytes in and normalized bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface upn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       final_char;

  modport source (output valid, output in_char, output final_char, input ready);
  modport sink   (input valid, input in_char, input final_char, output ready);
endinterface

interface upn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_last;
  logic       path_end;
  logic       bad_path;

  modport source (output valid, output out_char, output char_valid, output run_last,
                  output path_end, output bad_path, input ready);
  modport sink   (input valid, input out_char, input char_valid, input run_last,
                  input path_end, input bad_path, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/upn_parse.sv =====
// ----------------------------------------------------------------------------
// upn_parse
// Path scanner: holds the segment state and decodes one byte into the
// burst of result bytes it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upn_parse
  import upn_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] char_i,
  input  wire logic       fin_i,
  output upn_burst_t      burst_o
);

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_SLASH = 3'd1,
    MODE_DOT1  = 3'd2,
    MODE_NAME  = 3'd3,
    MODE_DOT2  = 3'd4
  } mode_e;

  mode_e mode_q, mode_d;
  logic  hold_q, hold_d;

  always_comb begin
    logic [CntW-1:0] n;
    logic            bad;
    n      = '0;
    bad    = 1'b0;
    burst_o = '0;
    mode_d = mode_q;
    hold_d = hold_q;

    if (hold_q) begin
      // skipping the rest of a bad path
      if (fin_i) begin
        burst_o.cnt          = CntW'(1);
        burst_o.item[0].last = 1'b1;
        burst_o.item[0].pend = 1'b1;
        hold_d = 1'b0;
        mode_d = MODE_START;
      end
    end else begin
      case (mode_q)
        MODE_SLASH: begin
          if (char_i == ChDot) begin
            mode_d = MODE_DOT1;
          end else if (char_i != ChSlash) begin
            burst_o.item[n[1:0]].ch  = char_i;
            burst_o.item[n[1:0]].vld = 1'b1;
            n = n + CntW'(1);
            mode_d = MODE_NAME;
          end
        end
        MODE_DOT1: begin
          if (char_i == ChSlash) begin
            mode_d = MODE_SLASH;
          end else if (char_i == ChDot) begin
            mode_d = MODE_DOT2;
          end else begin
            burst_o.item[0].ch  = ChDot;
            burst_o.item[0].vld = 1'b1;
            burst_o.item[1].ch  = char_i;
            burst_o.item[1].vld = 1'b1;
            n = CntW'(2);
            mode_d = MODE_NAME;
          end
        end
        MODE_NAME: begin
          burst_o.item[0].ch  = char_i;
          burst_o.item[0].vld = 1'b1;
          n = CntW'(1);
          if (char_i == ChSlash) begin
            mode_d = MODE_SLASH;
          end
        end
        MODE_DOT2: begin
          if (char_i == ChSlash) begin
            bad = 1'b1;
          end else begin
            burst_o.item[0].ch  = ChDot;
            burst_o.item[0].vld = 1'b1;
            burst_o.item[1].ch  = ChDot;
            burst_o.item[1].vld = 1'b1;
            burst_o.item[2].ch  = char_i;
            burst_o.item[2].vld = 1'b1;
            n = CntW'(3);
            mode_d = MODE_NAME;
          end
        end
        default: begin
          // start of path, and the unused codes
          if (char_i == ChSlash) begin
            burst_o.item[0].ch  = char_i;
            burst_o.item[0].vld = 1'b1;
            n = CntW'(1);
            mode_d = MODE_SLASH;
          end else begin
            bad = 1'b1;
          end
        end
      endcase

      if (bad) begin
        burst_o.item         = '0;
        burst_o.cnt          = CntW'(1);
        burst_o.item[0].last = 1'b1;
        burst_o.item[0].bad  = 1'b1;
        burst_o.item[0].pend = fin_i;
        hold_d = ~fin_i;
        mode_d = MODE_START;
      end else begin
        if (fin_i) begin
          if (mode_d == MODE_NAME) begin
            burst_o.item[n[1:0]].ch  = ChSlash;
            burst_o.item[n[1:0]].vld = 1'b1;
            n = n + CntW'(1);
          end
          if (n == '0) begin
            // final byte emits nothing: bare end marker
            n = CntW'(1);
          end
          burst_o.item[2'(n - CntW'(1))].pend = 1'b1;
          mode_d = MODE_START;
        end
        if (n != '0) begin
          burst_o.item[2'(n - CntW'(1))].last = 1'b1;
        end
        burst_o.cnt = n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      hold_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      hold_q <= hold_d;
    end
  end

  // discard only ever runs from start of path
  a_hold_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (mode_q == MODE_START))
    else $error("discard active outside start of path");

endmodule

`default_nettype wire

// ===== rtl/core/url_path_normalizer.sv =====
// ----------------------------------------------------------------------------
// url_path_normalizer
// Streaming canonicalizer for an absolute URL path, one byte per transfer.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                             handshake
//  in_i     in   in_char[8], final_char                              valid/ready
//  out_o    out  out_char[8], char_valid, run_last, path_end, bad_path valid/ready
//
//  One input transfer per cycle while each byte yields at most one result and
//  the output is not stalled. A byte that yields n results (up to 4) holds
//  the input while the burst queue drains through the output register.
//  Each result is registered in the burst queue, then in the output register.
//  Reset returns the scanner to start of path and empties the queue.
//  Output stalls back up through the queue into in_i.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module url_path_normalizer
  import upn_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  upn_in_if.sink    in_i,
  upn_out_if.source out_o
);

  upn_burst_t            burst;
  upn_res_t [MaxRes-1:0] res_q, res_d;
  logic [CntW-1:0]       rem_q, rem_d;
  logic                  oval_q, oval_d;
  upn_res_t              opay_q;
  logic                  load;
  logic                  take;

  assign load = (rem_q != '0) && (!oval_q || out_o.ready);
  assign in_i.ready = (rem_q == '0) || ((rem_q == CntW'(1)) && load);
  assign take = in_i.valid && in_i.ready;

  upn_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (take),
    .char_i  (in_i.in_char),
    .fin_i   (in_i.final_char),
    .burst_o (burst)
  );

  always_comb begin
    res_d  = res_q;
    rem_d  = rem_q;
    oval_d = oval_q;
    if (load) begin
      oval_d = 1'b1;
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      rem_d = rem_q - CntW'(1);
    end else if (out_o.ready) begin
      oval_d = 1'b0;
    end
    if (take) begin
      res_d = burst.item;
      rem_d = burst.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load) begin
      opay_q <= res_q[0];
    end
  end

  assign out_o.valid      = oval_q;
  assign out_o.out_char   = opay_q.ch;
  assign out_o.char_valid = opay_q.vld;
  assign out_o.run_last   = opay_q.last;
  assign out_o.path_end   = opay_q.pend;
  assign out_o.bad_path   = opay_q.bad;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CntW'(MaxRes))
    else $error("burst queue count out of range");

  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (rem_q <= CntW'(1)))
    else $error("input taken over a pending burst");

  a_bad_nochar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_path) |-> (!out_o.char_valid && out_o.run_last))
    else $error("error flag carries a byte or is not a lone result");

  a_nochar_lone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.char_valid) |-> (out_o.run_last && out_o.out_char == '0))
    else $error("empty result not alone or not zeroed");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for url_path_normalizer. A fixed list of path bytes
// walks the special cases first, then randomly built paths follow, most
// well formed, some with dot-dot segments, missing slashes or raw noise.
// Every accepted byte runs through a local path scanner model, and each
// output transfer is checked against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import upn_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandItems  = 300;

  typedef enum logic [2:0] {
    ModeStart = 3'd0,
    ModeSlash = 3'd1,
    ModeDot1  = 3'd2,
    ModeName  = 3'd3,
    ModeDot2  = 3'd4
  } scan_mode_e;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         typed;
    upn_res_t   res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  upn_in_if  in_bus ();
  upn_out_if out_bus ();

  url_path_normalizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Scanner model state
  scan_mode_e scan_mode;
  bit         skip_rest;
  upn_res_t   byte_res[$];
  upn_res_t   pending_res[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned bad_seen;
  int unsigned paths_sent;
  int unsigned cycle_cnt;

  int unsigned burst_left;
  bit          gappy;

  int unsigned stall_left;
  int unsigned rx_mode;
  int unsigned rx_cycle;

  upn_res_t got_res;
  upn_res_t want_res;

  logic [7:0] path_q[$];

  // Expected results for the fixed part; typed-in rows are the obvious ones
  dir_row_t dir_rows[26] = '{
    '{ChSlash, 1'b0, 1'b1, '{ChSlash, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{8'h61,   1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChDot,   1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChDot,   1'b0, 1'b0, '0},
    '{8'h68,   1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChDot,   1'b0, 1'b0, '0},
    '{ChDot,   1'b0, 1'b0, '0},
    '{8'h78,   1'b1, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChDot,   1'b0, 1'b0, '0},
    '{ChDot,   1'b0, 1'b0, '0},
    '{ChSlash, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{8'hFF,   1'b0, 1'b0, '0},
    '{8'h00,   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{8'h00,   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ChSlash, 1'b1, 1'b1, '{ChSlash, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{ChDot,   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{ChSlash, 1'b0, 1'b0, '0},
    '{8'hFF,   1'b1, 1'b0, '0},
    '{8'h71,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{ChSlash, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}}
  };

  function automatic void push_path_byte(input logic [7:0] ch, input logic vld);
    upn_res_t r;
    r      = '0;
    r.ch   = vld ? ch : 8'h00;
    r.vld  = vld;
    byte_res.insert(byte_res.size(), r);
  endfunction

  // Normalized bytes caused by one input byte, left in byte_res
  function automatic void normalize_byte(input logic [7:0] ch, input logic fin);
    bit is_bad;
    is_bad = 1'b0;
    byte_res.delete();
    if (skip_rest) begin
      if (fin) begin
        push_path_byte(8'h00, 1'b0);
        byte_res[0].last = 1'b1;
        byte_res[0].pend = 1'b1;
        skip_rest = 1'b0;
        scan_mode = ModeStart;
      end
      return;
    end
    case (scan_mode)
      ModeSlash: begin
        if (ch == ChDot) begin
          scan_mode = ModeDot1;
        end else if (ch != ChSlash) begin
          push_path_byte(ch, 1'b1);
          scan_mode = ModeName;
        end
      end
      ModeDot1: begin
        if (ch == ChSlash) begin
          scan_mode = ModeSlash;
        end else if (ch == ChDot) begin
          scan_mode = ModeDot2;
        end else begin
          push_path_byte(ChDot, 1'b1);
          push_path_byte(ch, 1'b1);
          scan_mode = ModeName;
        end
      end
      ModeName: begin
        push_path_byte(ch, 1'b1);
        if (ch == ChSlash) scan_mode = ModeSlash;
      end
      ModeDot2: begin
        if (ch == ChSlash) begin
          is_bad = 1'b1;
        end else begin
          push_path_byte(ChDot, 1'b1);
          push_path_byte(ChDot, 1'b1);
          push_path_byte(ch, 1'b1);
          scan_mode = ModeName;
        end
      end
      default: begin
        if (ch == ChSlash) begin
          push_path_byte(ch, 1'b1);
          scan_mode = ModeSlash;
        end else begin
          is_bad = 1'b1;
        end
      end
    endcase

    // Bytes emitted earlier in the path stand; this byte only flags
    if (is_bad) begin
      byte_res.delete();
      push_path_byte(8'h00, 1'b0);
      byte_res[0].last = 1'b1;
      byte_res[0].bad  = 1'b1;
      byte_res[0].pend = fin;
      skip_rest = !fin;
      scan_mode = ModeStart;
      return;
    end

    if (fin) begin
      if (scan_mode == ModeName) push_path_byte(ChSlash, 1'b1);
      if (byte_res.size() == 0) push_path_byte(8'h00, 1'b0);
      byte_res[byte_res.size() - 1].pend = 1'b1;
      scan_mode = ModeStart;
    end
    if (byte_res.size() > 0) byte_res[byte_res.size() - 1].last = 1'b1;
  endfunction

  // One input transfer, with sender bursts and gaps, then prediction
  task automatic send_byte(input logic [7:0] ch, input logic fin, input bit typed,
                           input upn_res_t typed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = gappy ? $urandom_range(1, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        in_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_bus.valid      = 1'b1;
    in_bus.in_char    = ch;
    in_bus.final_char = fin;
    do @(posedge clk_i); while (!in_bus.ready);
    burst_left--;
    items_sent++;
    if (fin) paths_sent++;
    normalize_byte(ch, fin);
    if (typed) begin
      pending_res.insert(pending_res.size(), typed_res);
    end else begin
      foreach (byte_res[k]) pending_res.insert(pending_res.size(), byte_res[k]);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    burst_left   = 0;
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] name_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 8'h61 + 8'($urandom_range(0, 25));
    if (pick == 6) return ChDot;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed paths; a few with errors or raw noise
  function automatic void build_path();
    int unsigned n_seg;
    int unsigned kind;
    int unsigned len;
    path_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      len = $urandom_range(1, 6);
      repeat (len) path_q.insert(path_q.size(), 8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 11) == 0) path_q.insert(path_q.size(), name_byte());
    else path_q.insert(path_q.size(), ChSlash);
    n_seg = $urandom_range(0, 4);
    for (int i = 0; i < n_seg; i++) begin
      kind = $urandom_range(0, 15);
      case (kind)
        0, 1: path_q.insert(path_q.size(), ChDot);
        2: begin
          path_q.insert(path_q.size(), ChDot);
          path_q.insert(path_q.size(), ChDot);
        end
        3: ;
        4, 5: begin
          path_q.insert(path_q.size(), ChDot);
          len = $urandom_range(1, 3);
          repeat (len) path_q.insert(path_q.size(), name_byte());
        end
        default: begin
          len = $urandom_range(1, 5);
          repeat (len) path_q.insert(path_q.size(), name_byte());
        end
      endcase
      if (i + 1 < n_seg || $urandom_range(0, 1) == 1) path_q.insert(path_q.size(), ChSlash);
      if ($urandom_range(0, 9) == 0) path_q.insert(path_q.size(), ChSlash);
    end
  endfunction

  // Receiver: random stall pattern whose flavor is redrawn at random during the run
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else begin
      out_bus.ready = 1'b1;
      case (rx_mode)
        1: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 3);
        2: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 6);
        default: ;
      endcase
    end
    rx_cycle++;
    if (rx_cycle % 53 == 0) rx_mode = $urandom_range(0, 2);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got_res.ch   = out_bus.out_char;
      got_res.vld  = out_bus.char_valid;
      got_res.last = out_bus.run_last;
      got_res.pend = out_bus.path_end;
      got_res.bad  = out_bus.bad_path;
      results_seen++;
      if (got_res.bad) bad_seen++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected transfer ch=%h vld=%b last=%b end=%b bad=%b", $time,
                 got_res.ch, got_res.vld, got_res.last, got_res.pend, got_res.bad);
        errors++;
      end else begin
        want_res = pending_res.pop_front();
        if (got_res.ch !== want_res.ch || got_res.vld !== want_res.vld ||
            got_res.last !== want_res.last || got_res.pend !== want_res.pend ||
            got_res.bad !== want_res.bad) begin
          $display("%0t: mismatch expected ch=%h vld=%b last=%b end=%b bad=%b", $time,
                   want_res.ch, want_res.vld, want_res.last, want_res.pend, want_res.bad);
          $display("%0t:          actual   ch=%h vld=%b last=%b end=%b bad=%b", $time,
                   got_res.ch, got_res.vld, got_res.last, got_res.pend, got_res.bad);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_res.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.in_char    = 8'h00;
    in_bus.final_char = 1'b0;
    out_bus.ready     = 1'b0;
    scan_mode         = ModeStart;
    skip_rest         = 1'b0;
    errors            = 0;
    items_sent        = 0;
    results_seen      = 0;
    bad_seen          = 0;
    paths_sent        = 0;
    cycle_cnt         = 0;
    burst_left        = 0;
    gappy             = 1'b0;
    stall_left        = 0;
    rx_mode           = 0;
    rx_cycle          = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].res);
    end
    // Close whatever the fixed part left open, then let the queue empty
    send_byte(ChSlash, 1'b1, 1'b0, '0);
    drain_results();

    while (items_sent < RandItems + $size(dir_rows)) begin
      if ($urandom_range(0, 7) == 0) gappy = !gappy;
      build_path();
      foreach (path_q[j]) begin
        send_byte(path_q[j], (j == path_q.size() - 1), 1'b0, '0);
      end
      if (paths_sent % 23 == 0) drain_results();
    end

    drain_results();
    repeat (12) @(posedge clk_i);

    $display("Sent %0d path bytes in %0d paths; checked %0d output transfers,",
             items_sent, paths_sent, results_seen);
    $display("%0d of them error flags, under mixed sender gaps and receiver stalls.",
             bad_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
